[rtl/ntt_pkg.sv]
// Shared types, constants and constant functions of the NTT unit.
`default_nettype none
package ntt_pkg;

    localparam int DEF_MAX_LOG_SIZE = 10;

    localparam int            VAL_W    = 30;
    localparam int            IDX_W    = 10;
    localparam int            OP_W     = 2;
    localparam int            CFG_IW   = 1;
    localparam int            CFG_DW   = 4;

    localparam logic [63:0]   P64      = 64'd998244353;
    localparam logic [29:0]   P        = 30'd998244353;
    localparam logic [63:0]   ROOT     = 64'd3;
    localparam logic [30:0]   BARRETT_M = 31'((64'd1 << 60) / P64);

    localparam logic [3:0]    LOG_SIZE_RST = 4'd10;

    // Item opcodes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_XFORM = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_LOG_SIZE = 1'b0;
    localparam logic [CFG_IW-1:0] CFG_INVERSE  = 1'b1;

    // Multiplier pipeline depth is 4; wait counts derive from it
    localparam logic [1:0] WAIT_BF = 2'd1;
    localparam logic [1:0] WAIT_SC = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_WRITE, S_RD_ADDR, S_RD_DATA,
        S_BR, S_BR_CAP, S_BR_W0, S_BR_W1,
        S_BF_RD, S_BF_CAP, S_BF_TW, S_BF_WAIT, S_BF_WA, S_BF_WB,
        S_SC_RD, S_SC_MUL, S_SC_WAIT, S_SC_WB
    } t_state;

    typedef enum logic [1:0] {AS_ITEM, AS_SWAP, AS_BFLY, AS_SCALE} t_addr_sel;

    typedef enum logic [2:0] {
        WR_NONE, WR_ITEM, WR_SWAP_A, WR_SWAP_B, WR_BF_A, WR_BF_B, WR_SCALE
    } t_wr_sel;

    typedef enum logic [1:0] {MS_VW, MS_WS, MS_SC} t_mul_sel;

    typedef enum logic [1:0] {W_HOLD, W_ONE, W_MUL} t_w_op;

    typedef struct packed {
        logic      load_item;
        logic      xf_init;
        t_addr_sel addr_sel;
        t_wr_sel   wr_sel;
        logic      cap;
        t_mul_sel  mul_sel;
        t_w_op     w_op;
        logic      k_clr;
        logic      k_inc;
        logic      c_inc;
        logic      stage_next;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        logic k_last;
        logic k_swap;
        logic c_last;
        logic j_last;
        logic s_last;
        logic inverse;
        logic out_busy;
    } t_status;

    function automatic logic [29:0] f_pow_mod(input logic [63:0] base, input logic [31:0] ex);
        logic [63:0] acc;
        logic [63:0] b;
        logic [31:0] e;
        acc = 64'd1;
        b   = base % P64;
        e   = ex;
        for (int k = 0; k < 32; k++) begin
            if (e[0]) begin
                acc = (acc * b) % P64;
            end
            b = (b * b) % P64;
            e = e >> 1;
        end
        return acc[29:0];
    endfunction

    function automatic logic [29:0] f_stage_root(input int s, input logic inv);
        logic [29:0] r;
        r = f_pow_mod(ROOT, 32'((P64 - 64'd1) >> s));
        if (inv) begin
            r = f_pow_mod({34'd0, r}, 32'(P64 - 64'd2));
        end
        return r;
    endfunction

    function automatic logic [29:0] f_inv_pow2(input int lg);
        return f_pow_mod((P64 + 64'd1) >> 1, 32'(lg));
    endfunction

endpackage
`default_nettype wire

[rtl/number_theoretic_transform_unit.sv]
// Top level of the number theoretic transform unit modulo 998244353.
`default_nettype none
// In-place radix-2 NTT modulo 998244353 (root 3) over 2^log_size coefficients,
// log_size clamped to 1..MAX_LOG_SIZE. Op 0 writes a coefficient (reduced
// modulo p, dropped at or beyond n), op 2 reads one back as a result beat
// (0 beyond n), op 1 runs bit reversal, the butterfly stages and, with
// inverse_mode set, the 1/n scaling; op 3 is taken and ignored. Items are
// handled one at a time; a read waits for the output register to drain. In a
// transform each butterfly makes two trips through the single write port of
// the coefficient RAM and waits out the four-stage modular multiplier, with
// the twiddle update issued in the cycle after the v*w product.
// Write configuration only while the unit is idle; nothing gates it.
// The coefficient RAM has no reset; read only entries already written.
module number_theoretic_transform_unit
    import ntt_pkg::*;
#(
    parameter int MAX_LOG_SIZE = DEF_MAX_LOG_SIZE
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [IDX_W-1:0]  i_index,
    input  wire logic [VAL_W-1:0]  i_value,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [VAL_W-1:0]       o_result_value,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_IW-1:0] i_cfg_index,
    input  wire logic [CFG_DW-1:0] i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_st;

    // Sequencer: dispatches each beat and steps through the transform phases
    ntt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_st       (w_st),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    // Datapath: holds store, counters, twiddles and the result register
    ntt_dp #(
        .MAX_LOG_SIZE (MAX_LOG_SIZE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_index        (i_index),
        .i_value        (i_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_out_ready),
        .i_cmd          (w_cmd),
        .o_st           (w_st),
        .o_out_valid    (o_out_valid),
        .o_result_value (o_result_value)
    );

endmodule
`default_nettype wire

[rtl/ntt_ram.sv]
// Generic RAM: one write port, two read ports, registered read data.
`default_nettype none
module ntt_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic      [WIDTH-1:0]         o_rdata0,
    output logic      [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule
`default_nettype wire

[rtl/ntt_mulmod.sv]
// Four-stage pipelined modular multiplier with Barrett reduction.
`default_nettype none
module ntt_mulmod
    import ntt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic [VAL_W-1:0] i_a,
    input  wire logic [VAL_W-1:0] i_b,
    output logic      [VAL_W-1:0] o_p
);

    logic [59:0] r_x;
    logic [61:0] r_q2;
    logic [31:0] r_x2;
    logic [31:0] r_x3;
    logic [31:0] r_qp;
    logic [60:0] w_qp;
    logic [31:0] w_r;
    logic [31:0] w_p2;
    logic [31:0] w_p1;

    assign w_qp = 61'(r_q2[61:31]) * 61'(P);
    assign w_r  = r_x3 - r_qp;
    assign w_p1 = {2'd0, P};
    assign w_p2 = {1'b0, P, 1'b0};

    always_ff @(posedge i_clk) begin
        r_x  <= {30'd0, i_a} * {30'd0, i_b};
        r_q2 <= {31'd0, r_x[59:29]} * {31'd0, BARRETT_M};
        r_x2 <= r_x[31:0];
        r_qp <= w_qp[31:0];
        r_x3 <= r_x2;
        // Barrett estimate is low by at most two multiples
        if (w_r >= w_p2) begin
            o_p <= VAL_W'(w_r - w_p2);
        end else if (w_r >= w_p1) begin
            o_p <= VAL_W'(w_r - w_p1);
        end else begin
            o_p <= VAL_W'(w_r);
        end
    end

endmodule
`default_nettype wire

[rtl/ntt_ctrl.sv]
// Sequencer of the NTT unit: item dispatch, bit reversal, butterflies, scaling.
`default_nettype none
module ntt_ctrl
    import ntt_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic [OP_W-1:0] i_op,
    input  wire t_status         i_st,
    output logic                 o_in_ready,
    output t_cmd                 o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_wait, n_wait;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
        end
    end

    always_comb begin
        n_state = r_state;
        n_wait  = r_wait;
        o_in_ready         = 1'b0;
        o_cmd.load_item    = 1'b0;
        o_cmd.xf_init      = 1'b0;
        o_cmd.addr_sel     = AS_ITEM;
        o_cmd.wr_sel       = WR_NONE;
        o_cmd.cap          = 1'b0;
        o_cmd.mul_sel      = MS_VW;
        o_cmd.w_op         = W_HOLD;
        o_cmd.k_clr        = 1'b0;
        o_cmd.k_inc        = 1'b0;
        o_cmd.c_inc        = 1'b0;
        o_cmd.stage_next   = 1'b0;
        o_cmd.out_load     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    case (i_op)
                        OP_WRITE: n_state = S_WRITE;
                        OP_XFORM: begin
                            o_cmd.xf_init = 1'b1;
                            n_state       = S_BR;
                        end
                        OP_READ:  n_state = S_RD_ADDR;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_WRITE: begin
                o_cmd.wr_sel = WR_ITEM;
                n_state      = S_IDLE;
            end
            S_RD_ADDR: begin
                n_state = S_RD_DATA;
            end
            S_RD_DATA: begin
                if (!i_st.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_BR: begin
                o_cmd.addr_sel = AS_SWAP;
                if (i_st.k_swap) begin
                    n_state = S_BR_CAP;
                end else if (i_st.k_last) begin
                    n_state = S_BF_RD;
                end else begin
                    o_cmd.k_inc = 1'b1;
                end
            end
            S_BR_CAP: begin
                o_cmd.addr_sel = AS_SWAP;
                o_cmd.cap      = 1'b1;
                n_state        = S_BR_W0;
            end
            S_BR_W0: begin
                o_cmd.wr_sel = WR_SWAP_A;
                n_state      = S_BR_W1;
            end
            S_BR_W1: begin
                o_cmd.wr_sel = WR_SWAP_B;
                if (i_st.k_last) begin
                    n_state = S_BF_RD;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_BR;
                end
            end
            S_BF_RD: begin
                o_cmd.addr_sel = AS_BFLY;
                n_state        = S_BF_CAP;
            end
            S_BF_CAP: begin
                o_cmd.addr_sel = AS_BFLY;
                o_cmd.cap      = 1'b1;
                o_cmd.mul_sel  = MS_VW;
                n_state        = S_BF_TW;
            end
            S_BF_TW: begin
                o_cmd.mul_sel = MS_WS;
                n_wait        = WAIT_BF;
                n_state       = S_BF_WAIT;
            end
            S_BF_WAIT: begin
                if (r_wait == 2'd0) begin
                    n_state = S_BF_WA;
                end else begin
                    n_wait = r_wait - 2'd1;
                end
            end
            S_BF_WA: begin
                o_cmd.wr_sel = WR_BF_A;
                n_state      = S_BF_WB;
            end
            S_BF_WB: begin
                o_cmd.wr_sel = WR_BF_B;
                o_cmd.w_op   = i_st.j_last ? W_ONE : W_MUL;
                if (i_st.c_last) begin
                    if (!i_st.s_last) begin
                        o_cmd.stage_next = 1'b1;
                        n_state          = S_BF_RD;
                    end else if (i_st.inverse) begin
                        o_cmd.k_clr = 1'b1;
                        n_state     = S_SC_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.c_inc = 1'b1;
                    n_state     = S_BF_RD;
                end
            end
            S_SC_RD: begin
                o_cmd.addr_sel = AS_SCALE;
                n_state        = S_SC_MUL;
            end
            S_SC_MUL: begin
                o_cmd.addr_sel = AS_SCALE;
                o_cmd.mul_sel  = MS_SC;
                n_wait         = WAIT_SC;
                n_state        = S_SC_WAIT;
            end
            S_SC_WAIT: begin
                if (r_wait == 2'd0) begin
                    n_state = S_SC_WB;
                end else begin
                    n_wait = r_wait - 2'd1;
                end
            end
            S_SC_WB: begin
                o_cmd.wr_sel = WR_SCALE;
                if (i_st.k_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_SC_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

[rtl/ntt_dp.sv]
// Datapath of the NTT unit: store, address counters, twiddles, multiplier, output.
`default_nettype none
module ntt_dp
    import ntt_pkg::*;
#(
    parameter int MAX_LOG_SIZE = DEF_MAX_LOG_SIZE
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [IDX_W-1:0]  i_index,
    input  wire logic [VAL_W-1:0]  i_value,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_IW-1:0] i_cfg_index,
    input  wire logic [CFG_DW-1:0] i_cfg_data,
    input  wire logic              i_out_ready,
    input  wire t_cmd              i_cmd,
    output t_status                o_st,
    output logic                   o_out_valid,
    output logic [VAL_W-1:0]       o_result_value
);

    localparam int AW = MAX_LOG_SIZE;
    localparam int LW = $clog2(MAX_LOG_SIZE + 1);

    logic [3:0]       r_log_size;
    logic             r_inverse;
    logic [IDX_W-1:0] r_index;
    logic [VAL_W-1:0] r_value;
    logic [AW-1:0]    r_k;
    logic [AW-1:0]    r_c;
    logic [LW-1:0]    r_s;
    logic [VAL_W-1:0] r_w;
    logic [VAL_W-1:0] r_lo;
    logic [VAL_W-1:0] r_hi;
    logic [VAL_W-1:0] r_d;

    logic [LW-1:0]    w_lg;
    logic [AW-1:0]    w_mask;
    logic [AW-1:0]    w_rev_full;
    logic [AW-1:0]    w_rev;
    logic [LW-1:0]    w_sm1;
    logic [AW-1:0]    w_half;
    logic [AW-1:0]    w_hmask;
    logic [AW-1:0]    w_a;
    logic [AW-1:0]    w_b;
    logic             w_in_range;
    logic [VAL_W-1:0] w_item_val;
    logic [VAL_W-1:0] w_step;
    logic [VAL_W-1:0] w_scale;
    logic [30:0]      w_sum;
    logic [VAL_W-1:0] w_bf_a;
    logic [VAL_W-1:0] w_bf_b;

    logic [VAL_W-1:0] w_root_f [0:MAX_LOG_SIZE];
    logic [VAL_W-1:0] w_root_i [0:MAX_LOG_SIZE];
    logic [VAL_W-1:0] w_ninv   [0:MAX_LOG_SIZE];

    logic [AW-1:0]    w_raddr0, w_raddr1, w_waddr;
    logic             w_we;
    logic [VAL_W-1:0] w_wdata, w_q0, w_q1;
    logic [VAL_W-1:0] w_ma, w_mb, w_mul;

    generate
        for (genvar g = 0; g <= MAX_LOG_SIZE; g++) begin : g_tbl
            localparam logic [VAL_W-1:0] RF = f_stage_root(g, 1'b0);
            localparam logic [VAL_W-1:0] RI = f_stage_root(g, 1'b1);
            localparam logic [VAL_W-1:0] NI = f_inv_pow2(g);
            assign w_root_f[g] = RF;
            assign w_root_i[g] = RI;
            assign w_ninv[g]   = NI;
        end
    endgenerate

    // Clamp the configured length
    always_comb begin
        if (r_log_size == 4'd0) begin
            w_lg = LW'(1);
        end else if (32'(r_log_size) > MAX_LOG_SIZE) begin
            w_lg = LW'(MAX_LOG_SIZE);
        end else begin
            w_lg = LW'(r_log_size);
        end
    end

    assign w_mask = ~({AW{1'b1}} << w_lg);

    always_comb begin
        for (int b = 0; b < AW; b++) begin
            w_rev_full[b] = r_k[AW-1-b];
        end
    end
    assign w_rev = w_rev_full >> (LW'(AW) - w_lg);

    // Butterfly pair: insert a zero at bit s-1 of the counter
    assign w_sm1   = LW'(r_s - LW'(1));
    assign w_half  = AW'(1) << w_sm1;
    assign w_hmask = w_half - AW'(1);
    assign w_a     = ((r_c >> w_sm1) << r_s) | (r_c & w_hmask);
    assign w_b     = w_a | w_half;

    assign w_in_range = ((r_index >> w_lg) == '0);
    assign w_item_val = (r_value >= P) ? VAL_W'(r_value - P) : r_value;

    assign w_step  = r_inverse ? w_root_i[r_s] : w_root_f[r_s];
    assign w_scale = w_ninv[w_lg];

    assign w_sum  = {1'b0, r_lo} + {1'b0, w_mul};
    assign w_bf_a = (w_sum >= {1'b0, P}) ? VAL_W'(w_sum - {1'b0, P}) : w_sum[VAL_W-1:0];
    assign w_bf_b = (r_lo >= w_mul) ? VAL_W'(r_lo - w_mul)
                                    : VAL_W'({1'b0, r_lo} + {1'b0, P} - {1'b0, w_mul});

    assign o_st.k_last   = (r_k == w_mask);
    assign o_st.k_swap   = (r_k < w_rev);
    assign o_st.c_last   = (r_c == (w_mask >> 1));
    assign o_st.j_last   = ((r_c & w_hmask) == w_hmask);
    assign o_st.s_last   = (r_s == w_lg);
    assign o_st.inverse  = r_inverse;
    assign o_st.out_busy = o_out_valid && !i_out_ready;

    always_comb begin
        case (i_cmd.addr_sel)
            AS_SWAP: begin
                w_raddr0 = r_k;
                w_raddr1 = w_rev;
            end
            AS_BFLY: begin
                w_raddr0 = w_a;
                w_raddr1 = w_b;
            end
            AS_SCALE: begin
                w_raddr0 = r_k;
                w_raddr1 = r_k;
            end
            default: begin
                w_raddr0 = AW'(r_index);
                w_raddr1 = AW'(r_index);
            end
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_k;
        w_wdata = w_mul;
        case (i_cmd.wr_sel)
            WR_ITEM: begin
                w_we    = w_in_range;
                w_waddr = AW'(r_index);
                w_wdata = w_item_val;
            end
            WR_SWAP_A: begin
                w_we    = 1'b1;
                w_waddr = r_k;
                w_wdata = r_hi;
            end
            WR_SWAP_B: begin
                w_we    = 1'b1;
                w_waddr = w_rev;
                w_wdata = r_lo;
            end
            WR_BF_A: begin
                w_we    = 1'b1;
                w_waddr = w_a;
                w_wdata = w_bf_a;
            end
            WR_BF_B: begin
                w_we    = 1'b1;
                w_waddr = w_b;
                w_wdata = r_d;
            end
            WR_SCALE: begin
                w_we    = 1'b1;
                w_waddr = r_k;
                w_wdata = w_mul;
            end
            default: w_we = 1'b0;
        endcase
    end

    always_comb begin
        case (i_cmd.mul_sel)
            MS_WS: begin
                w_ma = r_w;
                w_mb = w_step;
            end
            MS_SC: begin
                w_ma = w_q0;
                w_mb = w_scale;
            end
            default: begin
                w_ma = w_q1;
                w_mb = r_w;
            end
        endcase
    end

    ntt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (2 ** AW)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (w_waddr),
        .i_wdata  (w_wdata),
        .i_raddr0 (w_raddr0),
        .i_raddr1 (w_raddr1),
        .o_rdata0 (w_q0),
        .o_rdata1 (w_q1)
    );

    ntt_mulmod u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_mul)
    );

    // Control state: configuration, counters, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_size  <= LOG_SIZE_RST;
            r_inverse   <= 1'b0;
            r_k         <= '0;
            r_c         <= '0;
            r_s         <= LW'(1);
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LOG_SIZE: r_log_size <= i_cfg_data[3:0];
                    CFG_INVERSE:  r_inverse  <= i_cfg_data[0];
                    default:      r_inverse  <= r_inverse;
                endcase
            end
            if (i_cmd.xf_init || i_cmd.k_clr) begin
                r_k <= '0;
            end else if (i_cmd.k_inc) begin
                r_k <= r_k + AW'(1);
            end
            if (i_cmd.xf_init || i_cmd.stage_next) begin
                r_c <= '0;
            end else if (i_cmd.c_inc) begin
                r_c <= r_c + AW'(1);
            end
            if (i_cmd.xf_init) begin
                r_s <= LW'(1);
            end else if (i_cmd.stage_next) begin
                r_s <= r_s + LW'(1);
            end
            if (i_cmd.out_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_index <= i_index;
            r_value <= i_value;
        end
        if (i_cmd.cap) begin
            r_lo <= w_q0;
            r_hi <= w_q1;
        end
        if (i_cmd.wr_sel == WR_BF_A) begin
            r_d <= w_bf_b;
        end
        if (i_cmd.xf_init) begin
            r_w <= VAL_W'(1);
        end else begin
            case (i_cmd.w_op)
                W_ONE:   r_w <= VAL_W'(1);
                W_MUL:   r_w <= w_mul;
                default: r_w <= r_w;
            endcase
        end
        if (i_cmd.out_load) begin
            o_result_value <= w_in_range ? w_q0 : '0;
        end
    end

endmodule
`default_nettype wire

[tb/ntt_result_checker.sv]
// Checker for the NTT unit: mirrors the coefficient store and compares read beats.
module ntt_result_checker
    import ntt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_ready,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [IDX_W-1:0]  i_index,
    input  wire logic [VAL_W-1:0]  i_value,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_ready,
    input  wire logic [VAL_W-1:0]  i_result_value,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_IW-1:0] i_cfg_index,
    input  wire logic [CFG_DW-1:0] i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam logic [63:0] MODULUS = 64'd998244353;
    localparam int DEPTH = 1 << DEF_MAX_LOG_SIZE;

    logic [VAL_W-1:0] coef [DEPTH];
    logic [VAL_W-1:0] expected_reads [$];
    logic [3:0]       cfg_log;
    logic             cfg_inv;

    function automatic logic [29:0] mul_mod(input logic [29:0] a, input logic [29:0] b);
        logic [63:0] t;
        t = {34'd0, a} * {34'd0, b};
        return 30'(t % MODULUS);
    endfunction

    function automatic logic [29:0] pow_mod(input logic [29:0] base, input logic [31:0] ex);
        logic [29:0] acc;
        logic [29:0] b;
        logic [31:0] e;
        acc = 30'd1;
        b   = base;
        e   = ex;
        while (e != 0) begin
            if (e[0]) begin
                acc = mul_mod(acc, b);
            end
            b = mul_mod(b, b);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic int active_log();
        if (cfg_log < 1) begin
            return 1;
        end
        if (cfg_log > DEF_MAX_LOG_SIZE) begin
            return DEF_MAX_LOG_SIZE;
        end
        return int'(cfg_log);
    endfunction

    task automatic run_transform();
        int lg;
        int n;
        int len;
        int half;
        int r;
        int x;
        logic [29:0] tmp;
        logic [29:0] step;
        logic [29:0] w;
        logic [29:0] u;
        logic [29:0] v;
        logic [30:0] sum;
        lg = active_log();
        n  = 1 << lg;
        // bit-reversal permutation
        for (int i = 0; i < n; i++) begin
            x = i;
            r = 0;
            for (int b = 0; b < lg; b++) begin
                r = (r << 1) | (x & 1);
                x = x >> 1;
            end
            if (i < r) begin
                tmp     = coef[i];
                coef[i] = coef[r];
                coef[r] = tmp;
            end
        end
        for (int s = 1; s <= lg; s++) begin
            len  = 1 << s;
            half = len >> 1;
            step = pow_mod(30'd3, 32'((MODULUS - 64'd1) >> s));
            if (cfg_inv) begin
                step = pow_mod(step, 32'(MODULUS - 64'd2));
            end
            for (int i = 0; i < n; i += len) begin
                w = 30'd1;
                for (int j = 0; j < half; j++) begin
                    u   = coef[i + j];
                    v   = mul_mod(coef[i + j + half], w);
                    sum = {1'b0, u} + {1'b0, v};
                    coef[i + j] = (sum >= 31'(MODULUS)) ? 30'(sum - 31'(MODULUS)) : sum[29:0];
                    coef[i + j + half] = (u >= v) ? u - v : 30'({1'b0, u} + 31'(MODULUS) - {1'b0, v});
                    w = mul_mod(w, step);
                end
            end
        end
        if (cfg_inv) begin
            tmp = pow_mod(30'(n), 32'(MODULUS - 64'd2));
            for (int i = 0; i < n; i++) begin
                coef[i] = mul_mod(coef[i], tmp);
            end
        end
    endtask

    task automatic predict_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                input logic [VAL_W-1:0] val);
        int n;
        n = 1 << active_log();
        case (op)
            OP_WRITE: begin
                if (int'(idx) < n) begin
                    coef[idx] = (val >= 30'(MODULUS)) ? val - 30'(MODULUS) : val;
                end
            end
            OP_XFORM: run_transform();
            OP_READ: expected_reads.push_back((int'(idx) < n) ? coef[idx] : '0);
            default: ;  // op 3: drop
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_log <= LOG_SIZE_RST;
            cfg_inv <= 1'b0;
            expected_reads.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_LOG_SIZE) begin
                    cfg_log <= i_cfg_data;
                end else begin
                    cfg_inv <= i_cfg_data[0];
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_reads.size() == 0) begin
                    $display("%0t: unexpected read beat, expected none, actual %0d",
                             $time, i_result_value);
                    o_fail_count <= o_fail_count + 1;
                end else if (expected_reads[0] !== i_result_value) begin
                    $display("%0t: result_value mismatch, expected %0d, actual %0d",
                             $time, expected_reads[0], i_result_value);
                    o_fail_count <= o_fail_count + 1;
                    void'(expected_reads.pop_front());
                end else begin
                    void'(expected_reads.pop_front());
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_item(i_op, i_index, i_value);
            end
        end
    end

    assign o_pending = expected_reads.size();

endmodule

[tb/tb_number_theoretic_transform_unit.sv]
// Testbench top for the NTT unit: stimulus, handshake idling and verdict.
module tb_number_theoretic_transform_unit;
    import ntt_pkg::*;

    localparam logic [OP_W-1:0] OP_NOP = 2'd3;  // ignored by the unit
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DEPTH = 1 << DEF_MAX_LOG_SIZE;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [OP_W-1:0]   i_op;
    logic [IDX_W-1:0]  i_index;
    logic [VAL_W-1:0]  i_value;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [VAL_W-1:0]  o_result_value;
    logic              i_cfg_we;
    logic [CFG_IW-1:0] i_cfg_index;
    logic [CFG_DW-1:0] i_cfg_data;

    int fail_count;
    int pending_reads;
    int idle_cycles;
    int item_count;
    bit calm;                 // no idling on either side while set
    bit [DEPTH-1:0] written;  // entries written since reset
    int cur_n;

    number_theoretic_transform_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_index        (i_index),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_value (o_result_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    ntt_result_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_index        (i_index),
        .i_value        (i_value),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_result_value (o_result_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending_reads)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Receiver: stall with a chance of about 27 in 100 unless in a calm stretch.
    always @(posedge i_clk) begin
        i_out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 27);
    end

    // Watchdog: a transform at full size runs with no beat on either channel,
    // so the limit must sit well above its run time.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL number_theoretic_transform_unit");
            $finish;
        end
    end

    // Drive one item and hold it until the beat is taken.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                             input logic [VAL_W-1:0] val);
        if (!calm && $urandom_range(99) < 27) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_index    <= idx;
        i_value    <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (op == OP_WRITE && int'(idx) < cur_n) begin
            written[idx] = 1'b1;
        end
        item_count++;
    endtask

    // Fill any entry below n that was never written, then transform.
    task automatic transform_filled();
        for (int k = 0; k < cur_n; k++) begin
            if (!written[k]) begin
                send_item(OP_WRITE, IDX_W'(k), VAL_W'($urandom));
            end
        end
        send_item(OP_XFORM, IDX_W'($urandom), VAL_W'($urandom));
    endtask

    // Hold off the sender until the unit is idle: a read behind any running
    // transform proves it finished, then drain every expected beat.
    task automatic quiesce();
        if (written[0]) begin
            send_item(OP_READ, '0, VAL_W'($urandom));
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reads != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [3:0] lg, input logic inv);
        int eff;
        quiesce();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_LOG_SIZE;
        i_cfg_data  <= lg;
        @(posedge i_clk);
        i_cfg_index <= CFG_INVERSE;
        i_cfg_data  <= CFG_DW'(inv);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        eff = (lg < 1) ? 1 : (lg > DEF_MAX_LOG_SIZE) ? DEF_MAX_LOG_SIZE : int'(lg);
        cur_n = 1 << eff;
    endtask

    // One random item: reads only hit written entries or indexes beyond n;
    // transforms only at small sizes, where filling the store stays cheap.
    task automatic random_item();
        int pick;
        logic [IDX_W-1:0] idx;
        pick = $urandom_range(99);
        idx  = ($urandom_range(3) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(cur_n - 1));
        if (pick < 8 && cur_n <= 32) begin
            transform_filled();
        end else if (pick < 12) begin
            send_item(OP_NOP, IDX_W'($urandom), VAL_W'($urandom));
        end else if (pick < 50 && (int'(idx) >= cur_n || written[idx])) begin
            send_item(OP_READ, idx, VAL_W'($urandom));
        end else begin
            send_item(OP_WRITE, idx, ($urandom_range(9) == 0) ? VAL_W'($urandom)
                                      : VAL_W'($urandom_range(998244352)));
        end
    endtask

    initial begin
        logic [3:0] lg;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_op        = OP_WRITE;
        i_index     = '0;
        i_value     = '0;
        i_out_ready = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_LOG_SIZE;
        i_cfg_data  = '0;
        idle_cycles = 0;
        item_count  = 0;
        calm        = 1'b0;
        written     = '0;
        cur_n       = DEPTH;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, reduction of values at or above p, op 3.
        send_item(OP_WRITE, '0, '0);
        send_item(OP_WRITE, 10'd1023, 30'd998244352);
        send_item(OP_WRITE, 10'd5, 30'h3fffffff);
        send_item(OP_WRITE, 10'd6, 30'd998244353);
        send_item(OP_NOP, 10'h3ff, 30'h3fffffff);
        send_item(OP_READ, '0, '0);
        send_item(OP_READ, 10'd1023, 30'h3fffffff);
        send_item(OP_READ, 10'd5, '0);
        send_item(OP_READ, 10'd6, '0);

        // Smallest size: writes beyond n dropped, reads beyond n give zero.
        set_config(4'd1, 1'b0);
        send_item(OP_WRITE, '0, 30'd7);
        send_item(OP_WRITE, 10'd1, 30'd998244352);
        send_item(OP_WRITE, 10'd2, 30'd1);
        send_item(OP_READ, 10'd2, '0);
        send_item(OP_READ, 10'h3ff, '0);
        send_item(OP_XFORM, '0, '0);
        send_item(OP_READ, '0, '0);
        send_item(OP_READ, 10'd1, '0);
        // Size register 0 clamps up to 1; inverse undoes the forward pass.
        set_config(4'd0, 1'b1);
        send_item(OP_XFORM, '0, '0);
        send_item(OP_READ, '0, '0);
        send_item(OP_READ, 10'd1, '0);

        // Random phases; phase 2 runs at full size via the clamped register
        // value 15, phase 5 at full size directly, phase 4 is the calm stretch.
        for (int ph = 0; ph < 6 || item_count < 100; ph++) begin
            if (ph == 2) begin
                lg = 4'd15;
            end else if (ph == 5) begin
                lg = 4'd10;
            end else begin
                lg = 4'($urandom_range(1, 5));
            end
            set_config(lg, 1'($urandom));
            calm = (ph == 4);
            if (ph == 2 || ph == 5) begin
                // Read back the entries that the directed writes first set
                send_item(OP_READ, 10'd1023, '0);
                send_item(OP_READ, 10'd5, '0);
                send_item(OP_READ, 10'd6, '0);
                send_item(OP_READ, '0, '0);
            end
            for (int k = 0; k < (calm ? 16 : 10); k++) begin
                random_item();
            end
        end
        calm = 1'b0;

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reads != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS number_theoretic_transform_unit");
        end else begin
            $display("FAIL number_theoretic_transform_unit");
        end
        $finish;
    end

endmodule

[files.f]
rtl/ntt_pkg.sv
rtl/ntt_ram.sv
rtl/ntt_mulmod.sv
rtl/ntt_ctrl.sv
rtl/ntt_dp.sv
rtl/number_theoretic_transform_unit.sv
tb/ntt_result_checker.sv
tb/tb_number_theoretic_transform_unit.sv
